/* sv/mrtu_pkg.sv */
// shared types and constants of the modbus rtu slave frame handler
package mrtu_pkg;

   localparam int DEF_RX_BYTES       = 256;
   localparam int DEF_TX_BYTES       = 64;
   localparam int DEF_REGISTER_SLOTS = 64;

   localparam logic [7:0]  FN_READ_HOLDING = 8'h03;
   localparam logic [7:0]  FN_WRITE_SINGLE = 8'h06;
   localparam logic [7:0]  FN_WRITE_MULTI  = 8'h10;
   localparam logic [7:0]  EXC_FLAG        = 8'h80;
   localparam logic [7:0]  EXC_ILLEGAL_ADDR  = 8'h02;
   localparam logic [7:0]  EXC_ILLEGAL_VALUE = 8'h03;
   localparam logic [7:0]  EXC_DEVICE_FAIL   = 8'h04;
   localparam logic [15:0] CRC_INIT        = 16'hFFFF;
   localparam logic [15:0] CRC_POLY        = 16'hA001;
   localparam logic [7:0]  DEF_DEVICE_ADDRESS = 8'd1;
   localparam logic [6:0]  DEF_IMPL_REGS      = 7'd64;

   localparam logic CSR_DEVICE_ADDRESS = 1'b0;
   localparam logic CSR_IMPL_REGS      = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE, ST_CHECK, ST_CK_RD, ST_CK_XOR, ST_CK_SH, ST_CK_RLO, ST_CK_RHI,
      ST_CK_CMP, ST_EXEC, ST_WS, ST_W_RHI, ST_W_RLO, ST_W_WR, ST_T_FETCH,
      ST_T_LOAD, ST_T_SH, ST_T_CLO, ST_T_CHI, ST_DONE
   } state_type;

   typedef enum logic [1:0] {RESP_EXC, RESP_READ, RESP_ECHO} resp_type;
   typedef enum logic [1:0] {PLAN_EXC, PLAN_READ, PLAN_WS, PLAN_WM} plan_type;
   typedef enum logic [2:0] {RD_CNT, RD_NEED_LO, RD_NEED_HI, RD_WR_HI, RD_WR_LO} rd_sel_type;
   typedef enum logic [1:0] {TX_NONE, TX_BODY, TX_CRC_LO, TX_CRC_HI} tx_sel_type;

   typedef struct packed {
      logic       rx_take;
      logic       rx_clear;
      logic       crc_init;
      logic       crc_xor_rd;
      logic       crc_xor_tx;
      logic       crc_shift;
      logic       cnt_clr;
      logic       cnt_inc;
      rd_sel_type rd_sel;
      logic       byte_cap;
      logic       set_resp;
      logic       hr_rd;
      logic       hr_wr_single;
      logic       hr_wr_multi;
      tx_sel_type tx_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic     drop;
      logic     bit_last;
      logic     ck_last;
      logic     crc_ok;
      plan_type plan;
      logic     qty_zero;
      logic     w_last;
      logic     body_last;
      logic     out_free;
   } dp_stat_type;

endpackage

/* sv/mrtu_ctrl.sv */
// controller state machine sequencing frame check, register access and response
module mrtu_ctrl import mrtu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tlast,
   output logic        req_tready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_tvalid && req_tlast) state_in = ST_CHECK;
         ST_CHECK:   state_in = stat.drop ? ST_DONE : ST_CK_RD;
         ST_CK_RD:   state_in = ST_CK_XOR;
         ST_CK_XOR:  state_in = ST_CK_SH;
         ST_CK_SH:   if (stat.bit_last) state_in = stat.ck_last ? ST_CK_RLO : ST_CK_RD;
         ST_CK_RLO:  state_in = ST_CK_RHI;
         ST_CK_RHI:  state_in = ST_CK_CMP;
         ST_CK_CMP:  state_in = stat.crc_ok ? ST_EXEC : ST_DONE;
         ST_EXEC: begin
            unique case (stat.plan)
               PLAN_WS: state_in = ST_WS;
               PLAN_WM: state_in = stat.qty_zero ? ST_T_FETCH : ST_W_RHI;
               default: state_in = ST_T_FETCH;
            endcase
         end
         ST_WS:      state_in = ST_T_FETCH;
         ST_W_RHI:   state_in = ST_W_RLO;
         ST_W_RLO:   state_in = ST_W_WR;
         ST_W_WR:    state_in = stat.w_last ? ST_T_FETCH : ST_W_RHI;
         ST_T_FETCH: state_in = ST_T_LOAD;
         ST_T_LOAD:  if (stat.out_free) state_in = ST_T_SH;
         ST_T_SH:    if (stat.bit_last) state_in = stat.body_last ? ST_T_CLO : ST_T_FETCH;
         ST_T_CLO:   if (stat.out_free) state_in = ST_T_CHI;
         ST_T_CHI:   if (stat.out_free) state_in = ST_DONE;
         ST_DONE:    state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.rd_sel = RD_CNT;
      cmd.tx_sel = TX_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.rx_take = req_tvalid;
         end
         ST_CHECK: begin
            cmd.crc_init = 1'b1;
            cmd.cnt_clr  = 1'b1;
         end
         ST_CK_XOR: cmd.crc_xor_rd = 1'b1;
         ST_CK_SH: begin
            cmd.crc_shift = 1'b1;
            cmd.cnt_inc   = stat.bit_last;
         end
         ST_CK_RLO: cmd.rd_sel = RD_NEED_LO;
         ST_CK_RHI: begin
            cmd.rd_sel   = RD_NEED_HI;
            cmd.byte_cap = 1'b1;
         end
         ST_EXEC: begin
            cmd.set_resp = 1'b1;
            cmd.crc_init = 1'b1;
            cmd.cnt_clr  = 1'b1;
         end
         ST_WS:    cmd.hr_wr_single = 1'b1;
         ST_W_RHI: cmd.rd_sel = RD_WR_HI;
         ST_W_RLO: begin
            cmd.rd_sel   = RD_WR_LO;
            cmd.byte_cap = 1'b1;
         end
         ST_W_WR: begin
            cmd.hr_wr_multi = 1'b1;
            cmd.cnt_clr     = stat.w_last;
            cmd.cnt_inc     = !stat.w_last;
         end
         ST_T_FETCH: cmd.hr_rd = 1'b1;
         ST_T_LOAD: if (stat.out_free) begin
            cmd.tx_sel     = TX_BODY;
            cmd.crc_xor_tx = 1'b1;
         end
         ST_T_SH: begin
            cmd.crc_shift = 1'b1;
            cmd.cnt_inc   = stat.bit_last;
         end
         ST_T_CLO: if (stat.out_free) cmd.tx_sel = TX_CRC_LO;
         ST_T_CHI: if (stat.out_free) cmd.tx_sel = TX_CRC_HI;
         ST_DONE:  cmd.rx_clear = 1'b1;
         default: ;
      endcase
   end

endmodule

/* sv/mrtu_dp.sv */
// datapath: frame buffer, holding registers, crc unit, counters and output register
module mrtu_dp import mrtu_pkg::*; #(
   parameter int RX_BYTES       = DEF_RX_BYTES,
   parameter int TX_BYTES       = DEF_TX_BYTES,
   parameter int REGISTER_SLOTS = DEF_REGISTER_SLOTS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_wdata,
   input  logic [7:0]  rx_byte,
   input  logic        rsp_tready,
   output logic        rsp_tvalid,
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast,
   output logic        rsp_tuser,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat
);

   localparam int AW    = $clog2(RX_BYTES);
   localparam int CW    = $clog2(RX_BYTES + 2);
   localparam int HR_AW = (REGISTER_SLOTS > 1) ? $clog2(REGISTER_SLOTS) : 1;

   logic [7:0]       dev_ff, impl_ff;
   logic [CW-1:0]    rx_cnt_ff;
   logic [7:0]       hdr_ff [7];
   logic [7:0]       fmem [RX_BYTES];
   logic [7:0]       rd_ff;
   logic [AW-1:0]    rd_addr;
   logic [15:0]      crc_ff, crc_in, crc_sh;
   logic [2:0]       bit_ff;
   logic [15:0]      cnt_ff;
   logic [7:0]       hold_ff;
   resp_type         resp_ff;
   logic [7:0]       code_ff, code_in;
   plan_type         plan_sel;
   logic [15:0]      hmem [REGISTER_SLOTS];
   logic [REGISTER_SLOTS-1:0] hvalid_ff;
   logic [15:0]      hq_ff;
   logic             hv_ff;
   logic [15:0]      hval;
   logic [HR_AW-1:0] h_rd_addr, h_wr_addr;
   logic [15:0]      h_wr_data;
   logic             h_we;
   logic             out_valid_ff, out_last_ff, out_exc_ff;
   logic [7:0]       out_data_ff, body_byte;
   logic [9:0]       n, need;
   logic [7:0]       fn;
   logic [15:0]      start, qty;
   logic [16:0]      end_addr, qty2;
   logic [17:0]      size;
   logic [8:0]       limit;
   logic             fn3, fn6, fn10;
   logic [7:0]       body_len;
   logic [15:0]      rd_idx;

   assign n     = 10'(rx_cnt_ff);
   assign fn    = hdr_ff[1];
   assign fn3   = (fn == FN_READ_HOLDING);
   assign fn6   = (fn == FN_WRITE_SINGLE);
   assign fn10  = (fn == FN_WRITE_MULTI);
   assign need  = fn10 ? (10'd9 + 10'(hdr_ff[6])) : 10'd8;
   assign start = {hdr_ff[2], hdr_ff[3]};
   assign qty   = {hdr_ff[4], hdr_ff[5]};
   assign end_addr = 17'(start) + 17'(qty);
   assign qty2  = {qty, 1'b0};
   assign size  = 18'd5 + 18'(qty2);
   assign limit = (9'(impl_ff) < 9'(REGISTER_SLOTS)) ? 9'(impl_ff) : 9'(REGISTER_SLOTS);

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         dev_ff  <= DEF_DEVICE_ADDRESS;
         impl_ff <= {1'b0, DEF_IMPL_REGS};
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEVICE_ADDRESS: dev_ff  <= csr_wdata;
            CSR_IMPL_REGS:      impl_ff <= {1'b0, csr_wdata[6:0]};
            default: ;
         endcase
      end
   end

   // receive side
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_cnt_ff <= '0;
      end else if (cmd.rx_clear) begin
         rx_cnt_ff <= '0;
      end else if (cmd.rx_take) begin
         if (rx_cnt_ff < CW'(RX_BYTES)) rx_cnt_ff <= rx_cnt_ff + 1'b1;
         else                           rx_cnt_ff <= CW'(RX_BYTES + 1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rx_take && rx_cnt_ff < CW'(7)) hdr_ff[rx_cnt_ff[2:0]] <= rx_byte;
   end

   // frame buffer
   always_comb begin
      unique case (cmd.rd_sel)
         RD_NEED_LO: rd_addr = AW'(need - 10'd2);
         RD_NEED_HI: rd_addr = AW'(need - 10'd1);
         RD_WR_HI:   rd_addr = AW'(17'd7 + {cnt_ff, 1'b0});
         RD_WR_LO:   rd_addr = AW'(17'd8 + {cnt_ff, 1'b0});
         default:    rd_addr = cnt_ff[AW-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.rx_take && rx_cnt_ff < CW'(RX_BYTES)) fmem[rx_cnt_ff[AW-1:0]] <= rx_byte;
      rd_ff <= fmem[rd_addr];
   end

   // crc unit, one bit per cycle
   assign crc_sh = crc_ff[0] ? ((crc_ff >> 1) ^ CRC_POLY) : (crc_ff >> 1);

   always_comb begin
      priority if (cmd.crc_init)   crc_in = CRC_INIT;
      else if (cmd.crc_xor_rd)     crc_in = crc_ff ^ {8'h00, rd_ff};
      else if (cmd.crc_xor_tx)     crc_in = crc_ff ^ {8'h00, body_byte};
      else if (cmd.crc_shift)      crc_in = crc_sh;
      else                         crc_in = crc_ff;
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
      if (reset) begin
         bit_ff <= '0;
      end else if (cmd.crc_xor_rd || cmd.crc_xor_tx) begin
         bit_ff <= '0;
      end else if (cmd.crc_shift) begin
         bit_ff <= bit_ff + 1'b1;
      end
   end

   // shared counter
   always_ff @(posedge clock) begin
      if (reset || cmd.cnt_clr) cnt_ff <= '0;
      else if (cmd.cnt_inc)     cnt_ff <= cnt_ff + 1'b1;
      if (cmd.byte_cap) hold_ff <= rd_ff;
   end

   // response plan
   always_comb begin
      plan_sel = PLAN_EXC;
      code_in  = EXC_ILLEGAL_ADDR;
      priority if (fn3) begin
         priority if (size > 18'(TX_BYTES)) code_in = EXC_DEVICE_FAIL;
         else if (end_addr > 17'(limit))    code_in = EXC_ILLEGAL_ADDR;
         else                               plan_sel = PLAN_READ;
      end else if (fn6) begin
         if (start >= 16'(limit)) code_in = EXC_ILLEGAL_ADDR;
         else                     plan_sel = PLAN_WS;
      end else begin
         priority if (17'(hdr_ff[6]) != qty2) code_in = EXC_ILLEGAL_VALUE;
         else if (end_addr > 17'(limit))      code_in = EXC_ILLEGAL_ADDR;
         else                                 plan_sel = PLAN_WM;
      end
   end

   assign stat.plan = plan_sel;

   always_ff @(posedge clock) begin
      if (cmd.set_resp) begin
         code_ff <= code_in;
         unique case (plan_sel)
            PLAN_EXC:  resp_ff <= RESP_EXC;
            PLAN_READ: resp_ff <= RESP_READ;
            default:   resp_ff <= RESP_ECHO;
         endcase
      end
   end

   // holding registers
   assign rd_idx    = (cnt_ff - 16'd3) >> 1;
   assign h_rd_addr = HR_AW'(start + rd_idx);
   assign h_we      = cmd.hr_wr_single || cmd.hr_wr_multi;
   assign h_wr_addr = cmd.hr_wr_single ? HR_AW'(start) : HR_AW'(start + cnt_ff);
   assign h_wr_data = cmd.hr_wr_single ? qty : {hold_ff, rd_ff};

   always_ff @(posedge clock) begin
      if (h_we) hmem[h_wr_addr] <= h_wr_data;
      if (cmd.hr_rd) begin
         hq_ff <= hmem[h_rd_addr];
         hv_ff <= hvalid_ff[h_rd_addr];
      end
      if (reset)     hvalid_ff <= '0;
      else if (h_we) hvalid_ff[h_wr_addr] <= 1'b1;
   end

   assign hval = hv_ff ? hq_ff : 16'h0000;

   // response byte selection
   always_comb begin
      unique case (resp_ff)
         RESP_EXC: begin
            priority if (cnt_ff == 16'd0) body_byte = dev_ff;
            else if (cnt_ff == 16'd1)     body_byte = fn | EXC_FLAG;
            else                          body_byte = code_ff;
         end
         RESP_READ: begin
            priority if (cnt_ff == 16'd0) body_byte = dev_ff;
            else if (cnt_ff == 16'd1)     body_byte = fn;
            else if (cnt_ff == 16'd2)     body_byte = qty2[7:0];
            else if (!(cnt_ff[0]))        body_byte = hval[7:0];
            else                          body_byte = hval[15:8];
         end
         default: body_byte = (cnt_ff[2:0] < 3'd6) ? hdr_ff[cnt_ff[2:0]] : 8'h00;
      endcase
   end

   always_comb begin
      unique case (resp_ff)
         RESP_EXC:  body_len = 8'd3;
         RESP_READ: body_len = 8'd3 + qty2[7:0];
         default:   body_len = 8'd6;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.tx_sel != TX_NONE) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.tx_sel != TX_NONE) begin
         out_last_ff <= (cmd.tx_sel == TX_CRC_HI);
         out_exc_ff  <= (resp_ff == RESP_EXC);
         unique case (cmd.tx_sel)
            TX_CRC_LO: out_data_ff <= crc_ff[7:0];
            TX_CRC_HI: out_data_ff <= crc_ff[15:8];
            default:   out_data_ff <= body_byte;
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_exc_ff;

   // status
   assign stat.drop = (n > 10'(RX_BYTES)) || (n < 10'd4) || (hdr_ff[0] != dev_ff)
                      || !(fn3 || fn6 || fn10) || (fn10 && n < 10'd7) || (n < need);
   assign stat.bit_last  = (bit_ff == 3'd7);
   assign stat.ck_last   = (cnt_ff == 16'(need - 10'd3));
   assign stat.crc_ok    = (crc_ff == {rd_ff, hold_ff});
   assign stat.qty_zero  = (qty == 16'd0);
   assign stat.w_last    = (cnt_ff == qty - 16'd1);
   assign stat.body_last = (cnt_ff + 16'd1 == 16'(body_len));
   assign stat.out_free  = !out_valid_ff || rsp_tready;

endmodule

/* sv/modbus_rtu_slave_frame_handler.sv */
// top level of the modbus rtu slave frame handler
// a byte without frame end is taken in the idle state, where the port stays ready
// on a closing byte the frame is checked byte by byte with a bit-serial crc unit
// each response body byte passes through the same crc unit, a write-multiple first
// stores its registers one by one, and the port stays busy until the last byte is loaded
// synchronous reset clears counters and holding register valid bits, sets default config
module modbus_rtu_slave_frame_handler import mrtu_pkg::*; #(
   parameter int RX_BYTES       = DEF_RX_BYTES,
   parameter int TX_BYTES       = DEF_TX_BYTES,
   parameter int REGISTER_SLOTS = DEF_REGISTER_SLOTS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [0:0] csr_index,
   input  logic [7:0] csr_wdata,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // rx_byte
   input  logic       req_tlast,   // frame_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // tx_byte
   output logic       rsp_tlast,   // tx_last
   output logic       rsp_tuser    // is_exception
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   mrtu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mrtu_dp #(
      .RX_BYTES       (RX_BYTES),
      .TX_BYTES       (TX_BYTES),
      .REGISTER_SLOTS (REGISTER_SLOTS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rx_byte    (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule
